### hdl/sfrc_pkg.sv
package sfrc_pkg;

  localparam logic [7:0]  START_BYTE  = 8'hFD;
  localparam logic [7:0]  ESCAPE_BYTE = 8'hFC;
  localparam logic [7:0]  ESCAPE_MASK = 8'h80;
  localparam logic [15:0] CRC_POLY    = 16'h1002;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [3:0]  HDR_CONTROL = 4'd4;
  localparam logic [3:0]  HDR_SENDER_END = 4'd9;
  localparam logic [3:0]  DATA_PHASE  = 4'd15;
  localparam logic [6:0]  MAX_LEN_RESET = 7'd64;
  localparam logic [6:0]  CRC_BYTES   = 7'd2;
  localparam int          SENDER_FLAG_BIT = 3;

  typedef enum logic [1:0] {
    KIND_PAYLOAD    = 2'd0,
    KIND_EMPTY      = 2'd1,
    KIND_CRC_ERROR  = 2'd2,
    KIND_LEN_REJECT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_ACT,
    ST_RD,
    ST_PLAY
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] dest_address;
    logic [31:0] sender_address;
    logic [7:0]  control_byte;
    logic [5:0]  payload_length;
    logic [5:0]  byte_index;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

endpackage

### hdl/sfrc_if.sv
interface sfrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] dest_address;
  logic [31:0] sender_address;
  logic [7:0]  control_byte;
  logic [5:0]  payload_length;
  logic [5:0]  byte_index;
  logic [7:0]  data_byte;
  logic        last;

  modport source (output valid, output kind, output dest_address, output sender_address,
                  output control_byte, output payload_length, output byte_index,
                  output data_byte, output last, input ready);
  modport sink (input valid, input kind, input dest_address, input sender_address,
                input control_byte, input payload_length, input byte_index,
                input data_byte, input last, output ready);
endinterface

interface sfrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] max_frame_length;

  modport source (output valid, output max_frame_length, input ready);
  modport sink (input valid, input max_frame_length, output ready);
endinterface

### hdl/stuffed_frame_receiver_crc16_top.sv
// byte-stuffed frame receiver with crc-16 check
// in_ch: one raw line byte per item; out_ch: result items (payload bytes with the
// frame header, or a single status item); cfg_ch: write of max_frame_length, always ready
// an escape byte, or any byte outside a frame, is taken with no result
// a frame byte goes through accept, the bit-serial crc shifter and one step of
// header or data handling; the start byte goes through the shifter but has no handling step
// the last data byte of a good frame then plays the buffered payload out item by
// item (payload memory read, then output load); in_ch is not ready
// until the last payload item is loaded
// status items (crc error, rejected length, empty frame) are loaded into the output
// register by the byte handling
// the result sits in an output register; while out_ch stalls with an item in it,
// every frame byte waits in its handling cycle until that item is taken
// after reset no frame is open, the crc is preset and the length limit is 64;
// there is no clearing pass, the payload memory is only read after being written
module stuffed_frame_receiver_crc16_top #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  sfrc_in_if.sink     in_ch,
  sfrc_out_if.source  out_ch,
  sfrc_cfg_if.sink    cfg_ch
);

  localparam int DEPTH = (BUFFER_BYTES < 64) ? BUFFER_BYTES : 64;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [6:0] LEN_CAP = 7'(DEPTH);

  sfrc_pkg::state_t  state_r, state_nxt;
  logic [2:0]        bit_cnt_r, bit_cnt_nxt;
  logic              start_r, start_nxt;
  logic              esc_r, esc_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic [3:0]        hdr_r, hdr_nxt;
  logic [6:0]        dpos_r, dpos_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [31:0]       target_r, target_nxt;
  logic [31:0]       sender_r, sender_nxt;
  logic [7:0]        control_r, control_nxt;
  logic [6:0]        len_r, len_nxt;
  logic [5:0]        idx_r, idx_nxt;
  logic [6:0]        max_len_r;
  sfrc_pkg::result_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        rd_data_r;
  logic [7:0]        mem [0:DEPTH-1];

  logic        accept;
  logic        slot_free;
  logic [15:0] crc_step;
  logic [6:0]  limit;
  logic        in_hdr_target, in_hdr_ctrl, in_hdr_sender, in_hdr_len, in_data;
  logic [6:0]  dpos_inc;
  logic        frame_end;
  logic [5:0]  plen;
  logic        len_bad;
  logic        play_last;
  logic        mem_we;

  assign in_ch.ready  = (state_r == sfrc_pkg::ST_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign slot_free    = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // one crc bit per cycle, msb of the byte first
  assign crc_step = {crc_r[14:0], byte_r[3'd7 - bit_cnt_r]}
                  ^ (crc_r[15] ? sfrc_pkg::CRC_POLY : 16'h0000);

  assign limit = (max_len_r > LEN_CAP) ? LEN_CAP : max_len_r;

  assign in_hdr_target = (hdr_r < sfrc_pkg::HDR_CONTROL);
  assign in_hdr_ctrl   = (hdr_r == sfrc_pkg::HDR_CONTROL);
  assign in_hdr_sender = !in_hdr_target && !in_hdr_ctrl
                       && control_r[sfrc_pkg::SENDER_FLAG_BIT]
                       && (hdr_r < sfrc_pkg::HDR_SENDER_END);
  assign in_hdr_len    = !in_hdr_target && !in_hdr_ctrl && !in_hdr_sender
                       && (hdr_r != sfrc_pkg::DATA_PHASE);
  assign in_data       = (hdr_r == sfrc_pkg::DATA_PHASE);
  assign dpos_inc      = dpos_r + 7'd1;
  assign frame_end     = (dpos_inc == len_r);
  assign plen          = 6'(len_r - sfrc_pkg::CRC_BYTES);
  assign len_bad       = (byte_r < 8'd2) || (byte_r > {1'b0, limit});
  assign play_last     = ((idx_r + 6'd1) == plen);
  assign mem_we        = (state_r == sfrc_pkg::ST_ACT) && slot_free && in_data;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfrc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_ch.rx_byte == sfrc_pkg::START_BYTE) begin
            state_nxt = sfrc_pkg::ST_CRC;
          end else if (in_ch.rx_byte == sfrc_pkg::ESCAPE_BYTE && !esc_r) begin
            state_nxt = sfrc_pkg::ST_IDLE;
          end else if (in_frame_r) begin
            state_nxt = sfrc_pkg::ST_CRC;
          end
        end
      end
      sfrc_pkg::ST_CRC: begin
        if (bit_cnt_r == 3'd7) begin
          state_nxt = start_r ? sfrc_pkg::ST_IDLE : sfrc_pkg::ST_ACT;
        end
      end
      sfrc_pkg::ST_ACT: begin
        if (slot_free) begin
          if (in_data && frame_end && crc_r == 16'h0000 && plen != 6'd0) begin
            state_nxt = sfrc_pkg::ST_RD;
          end else begin
            state_nxt = sfrc_pkg::ST_IDLE;
          end
        end
      end
      sfrc_pkg::ST_RD: begin
        state_nxt = sfrc_pkg::ST_PLAY;
      end
      sfrc_pkg::ST_PLAY: begin
        if (slot_free) begin
          state_nxt = play_last ? sfrc_pkg::ST_IDLE : sfrc_pkg::ST_RD;
        end
      end
      default: begin
        state_nxt = sfrc_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    bit_cnt_nxt   = bit_cnt_r;
    start_nxt     = start_r;
    esc_nxt       = esc_r;
    in_frame_nxt  = in_frame_r;
    hdr_nxt       = hdr_r;
    dpos_nxt      = dpos_r;
    crc_nxt       = crc_r;
    byte_nxt      = byte_r;
    target_nxt    = target_r;
    sender_nxt    = sender_r;
    control_nxt   = control_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      sfrc_pkg::ST_IDLE: begin
        bit_cnt_nxt = 3'd0;
        if (accept) begin
          if (in_ch.rx_byte == sfrc_pkg::START_BYTE) begin
            in_frame_nxt = 1'b1;
            esc_nxt      = 1'b0;
            hdr_nxt      = 4'd0;
            dpos_nxt     = 7'd0;
            target_nxt   = 32'd0;
            sender_nxt   = 32'd0;
            crc_nxt      = sfrc_pkg::CRC_INIT;
            byte_nxt     = in_ch.rx_byte;
            start_nxt    = 1'b1;
          end else if (in_ch.rx_byte == sfrc_pkg::ESCAPE_BYTE && !esc_r) begin
            esc_nxt = 1'b1;
          end else if (in_frame_r) begin
            // a pending escape is consumed only by a byte inside a frame or by a start byte
            byte_nxt  = esc_r ? (in_ch.rx_byte | sfrc_pkg::ESCAPE_MASK) : in_ch.rx_byte;
            esc_nxt   = 1'b0;
            start_nxt = 1'b0;
          end
        end
      end
      sfrc_pkg::ST_CRC: begin
        crc_nxt     = crc_step;
        bit_cnt_nxt = bit_cnt_r + 3'd1;
      end
      sfrc_pkg::ST_ACT: begin
        if (slot_free) begin
          if (in_hdr_target) begin
            target_nxt = {target_r[23:0], byte_r};
            hdr_nxt    = hdr_r + 4'd1;
          end else if (in_hdr_ctrl) begin
            control_nxt = byte_r;
            hdr_nxt     = hdr_r + 4'd1;
          end else if (in_hdr_sender) begin
            sender_nxt = {sender_r[23:0], byte_r};
            hdr_nxt    = hdr_r + 4'd1;
          end else if (in_hdr_len) begin
            hdr_nxt = sfrc_pkg::DATA_PHASE;
            if (len_bad) begin
              len_nxt                = 7'd0;
              in_frame_nxt           = 1'b0;
              out_valid_nxt          = 1'b1;
              out_nxt.kind           = sfrc_pkg::KIND_LEN_REJECT;
              out_nxt.dest_address   = target_r;
              out_nxt.sender_address = sender_r;
              out_nxt.control_byte   = control_r;
              out_nxt.payload_length = 6'd0;
              out_nxt.byte_index     = 6'd0;
              out_nxt.data_byte      = 8'd0;
              out_nxt.last           = 1'b1;
            end else begin
              len_nxt = byte_r[6:0];
            end
          end else begin
            dpos_nxt = dpos_inc;
            if (frame_end) begin
              in_frame_nxt           = 1'b0;
              idx_nxt                = 6'd0;
              out_nxt.dest_address   = target_r;
              out_nxt.sender_address = sender_r;
              out_nxt.control_byte   = control_r;
              out_nxt.byte_index     = 6'd0;
              out_nxt.data_byte      = 8'd0;
              out_nxt.last           = 1'b1;
              if (crc_r != 16'h0000) begin
                out_valid_nxt          = 1'b1;
                out_nxt.kind           = sfrc_pkg::KIND_CRC_ERROR;
                out_nxt.payload_length = plen;
              end else if (plen == 6'd0) begin
                out_valid_nxt          = 1'b1;
                out_nxt.kind           = sfrc_pkg::KIND_EMPTY;
                out_nxt.payload_length = 6'd0;
              end
            end
          end
        end
      end
      sfrc_pkg::ST_RD: begin
        // memory read of idx_r lands in rd_data_r
      end
      sfrc_pkg::ST_PLAY: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.kind           = sfrc_pkg::KIND_PAYLOAD;
          out_nxt.dest_address   = target_r;
          out_nxt.sender_address = sender_r;
          out_nxt.control_byte   = control_r;
          out_nxt.payload_length = plen;
          out_nxt.byte_index     = idx_r;
          out_nxt.data_byte      = rd_data_r;
          out_nxt.last           = play_last;
          idx_nxt                = idx_r + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfrc_pkg::ST_IDLE;
      bit_cnt_r   <= 3'd0;
      start_r     <= 1'b0;
      esc_r       <= 1'b0;
      in_frame_r  <= 1'b0;
      hdr_r       <= 4'd0;
      dpos_r      <= 7'd0;
      crc_r       <= sfrc_pkg::CRC_INIT;
      target_r    <= 32'd0;
      sender_r    <= 32'd0;
      control_r   <= 8'd0;
      len_r       <= 7'd0;
      idx_r       <= 6'd0;
      max_len_r   <= sfrc_pkg::MAX_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      start_r     <= start_nxt;
      esc_r       <= esc_nxt;
      in_frame_r  <= in_frame_nxt;
      hdr_r       <= hdr_nxt;
      dpos_r      <= dpos_nxt;
      crc_r       <= crc_nxt;
      target_r    <= target_nxt;
      sender_r    <= sender_nxt;
      control_r   <= control_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        max_len_r <= cfg_ch.max_frame_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    out_r  <= out_nxt;
  end

  // payload buffer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[dpos_r[AW-1:0]] <= byte_r;
    end
    rd_data_r <= mem[idx_r[AW-1:0]];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.dest_address   = out_r.dest_address;
  assign out_ch.sender_address = out_r.sender_address;
  assign out_ch.control_byte   = out_r.control_byte;
  assign out_ch.payload_length = out_r.payload_length;
  assign out_ch.byte_index     = out_r.byte_index;
  assign out_ch.data_byte      = out_r.data_byte;
  assign out_ch.last           = out_r.last;

endmodule

### hdl/sfrc_checker.sv
module sfrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [5:0]  out_payload_length,
  input logic [5:0]  out_byte_index,
  input logic [7:0]  out_data_byte,
  input logic        out_last
);

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last)
      && $stable(out_byte_index) && $stable(out_data_byte))
    else $error("stalled result item changed");

  // status items stand alone
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != sfrc_pkg::KIND_PAYLOAD |-> out_last
      && out_byte_index == 6'd0 && out_data_byte == 8'd0)
    else $error("status item with payload fields");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == sfrc_pkg::KIND_LEN_REJECT || out_kind == sfrc_pkg::KIND_EMPTY)
      |-> out_payload_length == 6'd0)
    else $error("nonzero length on rejected or empty frame");

  // payload index stays inside the payload and last marks its end
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == sfrc_pkg::KIND_PAYLOAD |->
      out_byte_index < out_payload_length
      && (out_last == ((out_byte_index + 6'd1) == out_payload_length)))
    else $error("payload index or last flag out of place");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stuffed_frame_receiver_crc16_top sfrc_checker u_sfrc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_kind           (out_ch.kind),
  .out_payload_length (out_ch.payload_length),
  .out_byte_index     (out_ch.byte_index),
  .out_data_byte      (out_ch.data_byte),
  .out_last           (out_ch.last)
);
